>>> design/scheduled_link_loss_supervisor_core_defines.svh
// Assertion macros used by the supervisor core RTL.
`ifndef SCHEDULED_LINK_LOSS_SUPERVISOR_CORE_DEFINES_SVH
`define SCHEDULED_LINK_LOSS_SUPERVISOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Checked at every edge, also while reset is high.
`define SLLS_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("slls assertion failed");

// Checked only while reset is low.
`define SLLS_ASSERT_RUN(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("slls assertion failed");

`else

`define SLLS_ASSERT_ALWAYS(lbl, clk, prop)
`define SLLS_ASSERT_RUN(lbl, clk, rst, prop)

`endif

`endif

>>> design/slls_pkg.sv
package slls_pkg;

   localparam int unsigned TimeWidth  = 64;
   localparam int unsigned CountWidth = 32;

   typedef logic [TimeWidth-1:0]  time_type;
   typedef logic [CountWidth-1:0] count_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_WARM = 3'd1,
      PH_LIVE = 3'd2,
      PH_LOST = 3'd3,
      PH_DONE = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      REG_START    = 2'd0,
      REG_DURATION = 2'd1,
      REG_WARM_UP  = 2'd2,
      REG_SILENCE  = 2'd3
   } reg_index_type;

   // Schedule as seen by the phase engine, with the derived times precomputed.
   typedef struct packed {
      logic     armed;
      time_type start_time;
      time_type warm_time;
      time_type end_time;
      time_type silence_limit;
   } sched_type;

   typedef struct packed {
      time_type now_time;
      logic     link_healthy;
      time_type last_packet_time;
   } tick_type;

   typedef struct packed {
      phase_type phase;
      logic      phase_changed;
      logic      prepare_pulse;
      logic      release_pulse;
      logic      prepared;
      count_type losses;
      count_type recoveries;
      time_type  loss_time;
   } result_type;

endpackage

>>> design/scheduled_link_loss_supervisor_core.sv
// Scheduled link-loss supervisor.
// Ticks arrive on the req_ channel (valid/ready): current time, link health
// and the time of the last packet. Each tick yields exactly one result on the
// rsp_ channel: phase, change and prepare/release pulses, the prepared flag,
// loss and recovery counts and the time of the latest loss.
// Schedule registers are written through csr_; the user must write them only
// while no tick is in flight (the block does not enforce it); the derived
// warm-up and finish times are registered from the stored values. A tick
// passes the input register, where the phase engine evaluates it against the
// state, and then the result register. Throughput is one tick per cycle while
// the receiver keeps up, set by the phase update (64-bit compares and subtract
// on the input register). When the receiver stalls, the result register holds
// its transfer and the input register one more tick; req_ready drops only when
// both are full. Reset clears both stages, the phase state (idle, not prepared,
// counters and loss time zero) and the schedule registers to their defaults.
`include "scheduled_link_loss_supervisor_core_defines.svh"

module scheduled_link_loss_supervisor_core
   import slls_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_now_time,
   input  logic        req_link_healthy,
   input  logic [63:0] req_last_packet_time,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_phase,
   output logic        rsp_phase_changed,
   output logic        rsp_prepare_pulse,
   output logic        rsp_release_pulse,
   output logic        rsp_prepared,
   output logic [31:0] rsp_losses,
   output logic [31:0] rsp_recoveries,
   output logic [63:0] rsp_loss_time,

   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data
);

   sched_type  sched;
   tick_type   tick_ff, tick_in;
   logic       tick_valid_ff, tick_valid_in;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       advance;

   slls_cfg u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (reg_index_type'(csr_index)),
      .csr_write_data   (csr_write_data),
      .sched            (sched)
   );

   // A tick moves into the result register when that register is free or
   // being drained in the same cycle.
   assign advance   = tick_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !tick_valid_ff || advance;

   assign tick_in.now_time         = req_now_time;
   assign tick_in.link_healthy     = req_link_healthy;
   assign tick_in.last_packet_time = req_last_packet_time;

   assign tick_valid_in = (req_valid && req_ready) || (tick_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && !rsp_ready);

   slls_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .sched  (sched),
      .tick   (tick_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         tick_valid_ff <= tick_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         tick_ff <= tick_in;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_phase         = rsp_ff.phase;
   assign rsp_phase_changed = rsp_ff.phase_changed;
   assign rsp_prepare_pulse = rsp_ff.prepare_pulse;
   assign rsp_release_pulse = rsp_ff.release_pulse;
   assign rsp_prepared      = rsp_ff.prepared;
   assign rsp_losses        = rsp_ff.losses;
   assign rsp_recoveries    = rsp_ff.recoveries;
   assign rsp_loss_time     = rsp_ff.loss_time;

   // Input is refused only while both stages hold a tick.
   `SLLS_ASSERT_ALWAYS(a_ready_full, clock, !req_ready |-> (tick_valid_ff && rsp_valid_ff))
   // A release only happens on the finishing tick and leaves the input unprepared.
   `SLLS_ASSERT_RUN(a_release_done, clock, reset, (rsp_valid_ff && rsp_ff.release_pulse) |-> (rsp_ff.phase == PH_DONE && !rsp_ff.prepared && rsp_ff.phase_changed))
   // A prepare request comes only with the move into warm-up.
   `SLLS_ASSERT_RUN(a_prepare_warm, clock, reset, (rsp_valid_ff && rsp_ff.prepare_pulse) |-> (rsp_ff.phase == PH_WARM && rsp_ff.prepared && rsp_ff.phase_changed))
   // A held tick is not lost while the result side stalls.
   `SLLS_ASSERT_RUN(a_tick_held, clock, reset, (tick_valid_ff && !advance) |=> (tick_valid_ff && $stable(tick_ff)))

endmodule

>>> design/slls_cfg.sv
module slls_cfg
   import slls_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write_enable,
   input  reg_index_type csr_index,
   input  time_type      csr_write_data,
   output sched_type     sched
);

   time_type start_ff, start_in;
   time_type duration_ff, duration_in;
   time_type lead_ff, lead_in;
   time_type silence_ff, silence_in;
   time_type warm_ff, warm_in;
   time_type end_ff, end_in;
   logic     armed_ff, armed_in;
   logic [TimeWidth:0] end_sum;

   always_comb begin
      start_in   = start_ff;
      duration_in = duration_ff;
      lead_in    = lead_ff;
      silence_in = silence_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_START:    start_in    = csr_write_data;
            REG_DURATION: duration_in = csr_write_data;
            REG_WARM_UP:  lead_in     = csr_write_data;
            REG_SILENCE:  silence_in  = csr_write_data;
            default:      start_in    = start_ff;
         endcase
      end
   end

   // The derived times are registered from the stored schedule values.
   assign end_sum  = {1'b0, start_ff} + {1'b0, duration_ff};
   assign end_in   = end_sum[TimeWidth] ? {TimeWidth{1'b1}} : end_sum[TimeWidth-1:0];
   assign warm_in  = (start_ff > lead_ff) ? (start_ff - lead_ff) : '0;
   assign armed_in = (start_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff    <= '0;
         duration_ff <= time_type'(1);
         lead_ff     <= '0;
         silence_ff  <= '0;
         warm_ff     <= '0;
         end_ff      <= time_type'(1);
         armed_ff    <= 1'b0;
      end else begin
         start_ff    <= start_in;
         duration_ff <= duration_in;
         lead_ff     <= lead_in;
         silence_ff  <= silence_in;
         warm_ff     <= warm_in;
         end_ff      <= end_in;
         armed_ff    <= armed_in;
      end
   end

   assign sched.armed         = armed_ff;
   assign sched.start_time    = start_ff;
   assign sched.warm_time     = warm_ff;
   assign sched.end_time      = end_ff;
   assign sched.silence_limit = silence_ff;

endmodule

>>> design/slls_engine.sv
module slls_engine
   import slls_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  sched_type  sched,
   input  tick_type   tick,
   output result_type result
);

   phase_type phase_ff, phase_in;
   logic      prepared_ff, prepared_in;
   count_type losses_ff, losses_in;
   count_type recoveries_ff, recoveries_in;
   time_type  loss_time_ff, loss_time_in;

   logic active;
   logic past_end;
   logic silent;
   logic prepare_pulse;
   logic release_pulse;
   logic note_loss;
   logic note_recovery;

   assign active   = sched.armed && (phase_ff != PH_DONE);
   assign past_end = (tick.now_time >= sched.end_time);

   // A packet stamp ahead of the tick time does not count as silence.
   assign silent = (tick.last_packet_time == '0) ||
                   ((tick.now_time > tick.last_packet_time) &&
                    ((tick.now_time - tick.last_packet_time) > sched.silence_limit));

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (active) begin
         if (past_end) begin
            phase_in = PH_DONE;
         end else begin
            case (phase_ff)
               PH_IDLE: if (tick.now_time >= sched.warm_time) phase_in = PH_WARM;
               PH_WARM: begin
                  if (tick.now_time >= sched.start_time) begin
                     phase_in = tick.link_healthy ? PH_LIVE : PH_LOST;
                  end
               end
               PH_LIVE: if (silent || !tick.link_healthy) phase_in = PH_LOST;
               PH_LOST: if (tick.link_healthy) phase_in = PH_LIVE;
               default: phase_in = phase_ff;
            endcase
         end
      end
   end

   // Flags, pulses and counters.
   always_comb begin
      prepare_pulse = 1'b0;
      release_pulse = 1'b0;
      note_loss     = 1'b0;
      note_recovery = 1'b0;
      prepared_in   = prepared_ff;
      if (active) begin
         if (past_end) begin
            release_pulse = prepared_ff;
            prepared_in   = 1'b0;
         end else begin
            case (phase_ff)
               PH_IDLE: begin
                  if (tick.now_time >= sched.warm_time) begin
                     prepare_pulse = !prepared_ff;
                     prepared_in   = 1'b1;
                  end
               end
               PH_WARM: begin
                  note_loss = (tick.now_time >= sched.start_time) && !tick.link_healthy;
               end
               PH_LIVE:  note_loss     = silent || !tick.link_healthy;
               PH_LOST:  note_recovery = tick.link_healthy;
               default:  note_loss     = 1'b0;
            endcase
         end
      end
      losses_in     = note_loss ? losses_ff + count_type'(1) : losses_ff;
      loss_time_in  = note_loss ? tick.now_time : loss_time_ff;
      recoveries_in = note_recovery ? recoveries_ff + count_type'(1) : recoveries_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         prepared_ff   <= 1'b0;
         losses_ff     <= '0;
         recoveries_ff <= '0;
         loss_time_ff  <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         prepared_ff   <= prepared_in;
         losses_ff     <= losses_in;
         recoveries_ff <= recoveries_in;
         loss_time_ff  <= loss_time_in;
      end
   end

   assign result.phase         = phase_in;
   assign result.phase_changed = (phase_in != phase_ff);
   assign result.prepare_pulse = prepare_pulse;
   assign result.release_pulse = release_pulse;
   assign result.prepared      = prepared_in;
   assign result.losses        = losses_in;
   assign result.recoveries    = recoveries_in;
   assign result.loss_time     = loss_time_in;

endmodule
